// ----- rtl/vurp_pkg.sv -----
// Package for the video unit register port: request codes, register numbers,
// memory sizes and address helpers. No dependencies.
package vurp_pkg;

  localparam int unsigned NameMemDepth    = 2048;
  localparam int unsigned PatternMemDepth = 8192;
  localparam int unsigned SpriteMemDepth  = 256;
  localparam int unsigned PaletteDepth    = 32;

  localparam logic [1:0] ReqRead  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  localparam logic [2:0] RegCtrl   = 3'd0;
  localparam logic [2:0] RegStatus = 3'd2;
  localparam logic [2:0] RegOamAdr = 3'd3;
  localparam logic [2:0] RegOamDat = 3'd4;
  localparam logic [2:0] RegScroll = 3'd5;
  localparam logic [2:0] RegAddr   = 3'd6;
  localparam logic [2:0] RegData   = 3'd7;

  localparam logic [8:0] LastDot      = 9'd340;
  localparam logic [8:0] VblankLine   = 9'd241;
  localparam logic [8:0] PreLine      = 9'd261;
  localparam logic [13:0] PaletteBase = 14'h3f00;
  localparam logic [13:0] PatternTop  = 14'h2000;

  // memory target of one data port address
  typedef enum logic [1:0] {
    TgtPattern = 2'd0,
    TgtName    = 2'd1,
    TgtPalette = 2'd2
  } tgt_e;

  function automatic tgt_e addr_target(input logic [13:0] a);
    if (a < PatternTop) return TgtPattern;
    if (a < PaletteBase) return TgtName;
    return TgtPalette;
  endfunction

  function automatic logic [10:0] name_slot(input logic [13:0] a, input logic mirror_v);
    logic [11:0] off;
    logic        bank;
    off  = a[11:0];
    bank = mirror_v ? off[10] : off[11];
    return {bank, off[9:0]};
  endfunction

  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

endpackage

// ----- rtl/vurp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module vurp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/vurp_timing.sv -----
// Dot and line counter with vblank set and clear events.
// Depends on vurp_pkg.
module vurp_timing (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tick_i,
  output logic vbl_set_o,
  output logic vbl_clr_o
);
  logic [8:0] dot_q, dot_d, line_q, line_d;
  logic [8:0] dot_inc;

  always_comb begin
    dot_inc = dot_q + 9'd1;
    dot_d   = dot_q;
    line_d  = line_q;
    vbl_set_o = tick_i && line_q == vurp_pkg::VblankLine && dot_inc == 9'd1;
    vbl_clr_o = tick_i && line_q == vurp_pkg::PreLine && dot_inc == 9'd1;
    if (tick_i) begin
      dot_d = dot_inc;
      if (dot_inc > vurp_pkg::LastDot) begin
        dot_d  = '0;
        line_d = (line_q >= vurp_pkg::PreLine) ? 9'd0 : line_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= '0;
      line_q <= vurp_pkg::PreLine;
    end else begin
      dot_q  <= dot_d;
      line_q <= line_d;
    end
  end

  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q <= vurp_pkg::LastDot && line_q <= vurp_pkg::PreLine)
    else $error("counter out of range");
  a_set_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vbl_set_o && vbl_clr_o)) else $error("vblank set and clear together");
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && dot_q == vurp_pkg::LastDot |=> dot_q == 9'd0)
    else $error("dot wrap");
endmodule

// ----- rtl/video_unit_register_port.sv -----
// Top level of the video unit register port: request decode, pointer state,
// memories and output register. Depends on vurp_pkg, vurp_ram, vurp_timing.
// One request per clock, back to back, while not held or clearing (see below).
// Sprite, name table and pattern memories are synchronous RAMs: the edge that
// accepts a request registers its memory read data and puts it in stage 2; the
// output register then takes the response and raises m_axis_tvalid. A write is
// visible to a read accepted on the next edge, so no forwarding is needed. When
// the output register is full and not taken, the whole pipeline holds, the RAM
// read data included. After reset a clearing pass over all NAME_MEM_DEPTH (2048)
// name table addresses zeroes name table and sprite memories; s_axis_tready
// stays low until it ends. Palette entries are registers reset to zero.
module video_unit_register_port #(
  parameter int unsigned NAME_MEM_DEPTH    = vurp_pkg::NameMemDepth,
  parameter int unsigned PATTERN_MEM_DEPTH = vurp_pkg::PatternMemDepth,
  parameter int unsigned SPRITE_MEM_DEPTH  = vurp_pkg::SpriteMemDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_type[1:0], reg_index[4:2], write_data[12:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // read_data[7:0], nmi_request[8], vblank_now[9]
);
  localparam int unsigned NaW = $clog2(NAME_MEM_DEPTH);
  localparam int unsigned PaW = $clog2(PATTERN_MEM_DEPTH);
  localparam int unsigned SpW = $clog2(SPRITE_MEM_DEPTH);

  // ---- state ----
  logic       mirror_q;
  logic [7:0] ctrl_q, oam_q, latch_q;
  logic       vbl_q, wtog_q;
  logic [13:0] vptr_q, tptr_q;
  logic [7:0] pal_q [vurp_pkg::PaletteDepth];
  logic           clr_q;
  logic [NaW-1:0] clr_cnt_q;

  // ---- stage 1 (accept) ----
  logic       acc;
  logic [1:0] rtype;
  logic [2:0] ridx;
  logic [7:0] wdat;
  logic       adv, s2_stall;

  assign rtype = s_axis_tdata[1:0];
  assign ridx  = s_axis_tdata[4:2];
  assign wdat  = s_axis_tdata[12:5];
  assign acc   = s_axis_tvalid && s_axis_tready;

  // stage 2 holds a request whose memory data is being read
  logic        s2v_q;
  logic [7:0]  s2_rd_q;       // immediate result part
  logic        s2_nmi_q, s2_vbl_q;
  logic        s2_mem_q;      // result needs memory data (data port read)
  logic        s2_pal_q;      // palette read: rd from palette, latch from name mem
  logic        s2_ltgt_q;     // latch source: 0 name, 1 pattern
  logic        s2_spr_q;      // sprite read

  // output register
  logic       ov_q;
  logic [9:0] od_q;

  assign s2_stall = ov_q && !m_axis_tready;
  assign adv      = !s2_stall;
  assign s_axis_tready = adv && !clr_q;

  // ---- address of data port and sprite ----
  vurp_pkg::tgt_e tgt;
  logic [13:0] ladr;   // latch source address for palette reads
  logic [NaW-1:0] naddr;
  logic [PaW-1:0] paddr;
  logic [13:0] vinc;
  logic is_rd, is_wr;
  logic n_we, p_we, s_we;
  logic [NaW-1:0] nwa;
  logic [PaW-1:0] pwa;
  logic [SpW-1:0] swa;
  logic [7:0]     nwd, swd;

  assign is_rd = acc && rtype == vurp_pkg::ReqRead;
  assign is_wr = acc && rtype == vurp_pkg::ReqWrite;
  assign tgt   = vurp_pkg::addr_target(vptr_q);
  assign ladr  = vptr_q - 14'h1000;
  assign vinc  = vptr_q + (ctrl_q[2] ? 14'd32 : 14'd1);

  always_comb begin
    naddr = NaW'(vurp_pkg::name_slot(tgt == vurp_pkg::TgtPalette ? ladr : vptr_q, mirror_q));
    paddr = vptr_q[PaW-1:0];
  end

  // clearing pass owns the name and sprite write ports
  assign n_we = clr_q || (is_wr && ridx == vurp_pkg::RegData && tgt == vurp_pkg::TgtName);
  assign p_we = is_wr && ridx == vurp_pkg::RegData && tgt == vurp_pkg::TgtPattern;
  assign s_we = clr_q || (is_wr && ridx == vurp_pkg::RegOamDat);
  assign nwa  = clr_q ? clr_cnt_q : naddr;
  assign pwa  = paddr;
  assign swa  = clr_q ? clr_cnt_q[SpW-1:0] : oam_q[SpW-1:0];
  assign nwd  = clr_q ? 8'h00 : wdat;
  assign swd  = clr_q ? 8'h00 : wdat;

  logic [7:0] n_rdata, p_rdata, s_rdata;

  vurp_ram #(.Width(8), .Depth(NAME_MEM_DEPTH)) u_name (
    .clk_i, .we_i(n_we), .waddr_i(nwa), .wdata_i(nwd), .re_i(adv), .raddr_i(naddr),
    .rdata_o(n_rdata));
  vurp_ram #(.Width(8), .Depth(PATTERN_MEM_DEPTH)) u_pat (
    .clk_i, .we_i(p_we), .waddr_i(pwa), .wdata_i(wdat), .re_i(adv), .raddr_i(paddr),
    .rdata_o(p_rdata));
  vurp_ram #(.Width(8), .Depth(SPRITE_MEM_DEPTH)) u_spr (
    .clk_i, .we_i(s_we), .waddr_i(swa), .wdata_i(swd), .re_i(adv),
    .raddr_i(oam_q[SpW-1:0]), .rdata_o(s_rdata));

  // timing
  logic vbl_set, vbl_clr;
  vurp_timing u_timing (
    .clk_i, .rst_ni, .tick_i(acc && rtype == vurp_pkg::ReqTick),
    .vbl_set_o(vbl_set), .vbl_clr_o(vbl_clr));

  // ---- stage 1 combinational decode ----
  logic       vbl_d, wtog_d;
  logic [7:0] ctrl_d, oam_d;
  logic [13:0] vptr_d, tptr_d;
  logic [7:0] rd_imm;
  logic       nmi_imm, mem_d, pal_d, ltgt_d, spr_d;

  always_comb begin
    vbl_d = vbl_q; wtog_d = wtog_q; ctrl_d = ctrl_q; oam_d = oam_q;
    vptr_d = vptr_q; tptr_d = tptr_q;
    rd_imm = '0; nmi_imm = 1'b0; mem_d = 1'b0; pal_d = 1'b0; ltgt_d = 1'b0; spr_d = 1'b0;
    if (acc) begin
      case (rtype)
        vurp_pkg::ReqRead: begin
          case (ridx)
            vurp_pkg::RegStatus: begin
              rd_imm = {vbl_q, 2'b00, latch_q[4:0]};
              vbl_d = 1'b0; wtog_d = 1'b0;
            end
            vurp_pkg::RegOamDat: spr_d = 1'b1;
            vurp_pkg::RegData: begin
              mem_d  = 1'b1;
              vptr_d = vinc;
              if (tgt == vurp_pkg::TgtPalette) begin
                pal_d  = 1'b1;
                rd_imm = pal_q[vurp_pkg::pal_slot(vptr_q)];
                ltgt_d = 1'b0;
              end else begin
                rd_imm = latch_q;
                ltgt_d = (tgt == vurp_pkg::TgtPattern);
              end
            end
            default: ;
          endcase
        end
        vurp_pkg::ReqWrite: begin
          case (ridx)
            vurp_pkg::RegCtrl:   ctrl_d = wdat;
            vurp_pkg::RegOamAdr: oam_d = wdat;
            vurp_pkg::RegOamDat: oam_d = oam_q + 8'd1;
            vurp_pkg::RegScroll: wtog_d = !wtog_q;
            vurp_pkg::RegAddr: begin
              if (!wtog_q) tptr_d = {wdat[5:0], 8'h00};
              else begin
                tptr_d = {tptr_q[13:8], wdat};
                vptr_d = {tptr_q[13:8], wdat};
              end
              wtog_d = !wtog_q;
            end
            vurp_pkg::RegData: vptr_d = vinc;
            default: ;
          endcase
        end
        vurp_pkg::ReqTick: begin
          if (vbl_set) begin
            vbl_d = 1'b1; nmi_imm = ctrl_q[7];
          end else if (vbl_clr) vbl_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // latch is loaded in stage 2 from memory data; a stage-1 status read of
  // latch must see it, so forward the stage-2 load
  logic [7:0] s2_ld;
  logic       s2_ld_en;
  assign s2_ld = s2_ltgt_q ? p_rdata : n_rdata;
  assign s2_ld_en = s2v_q && s2_mem_q && adv;
  logic [7:0] latch_eff;
  assign latch_eff = s2_ld_en ? s2_ld : latch_q;

  // fix up rd_imm with forwarded latch (status or data read of latch)
  logic [7:0] rd1;
  always_comb begin
    rd1 = rd_imm;
    if (is_rd && ridx == vurp_pkg::RegStatus)
      rd1 = {vbl_q, 2'b00, latch_eff[4:0]};
    else if (is_rd && ridx == vurp_pkg::RegData && !pal_d)
      rd1 = latch_eff;
  end

  // palette write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(vurp_pkg::PaletteDepth); i++) pal_q[i] <= '0;
    end else if (is_wr && ridx == vurp_pkg::RegData && tgt == vurp_pkg::TgtPalette) begin
      pal_q[vurp_pkg::pal_slot(vptr_q)] <= wdat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 1'b0; ctrl_q <= '0; oam_q <= '0; latch_q <= '0;
      vbl_q <= 1'b0; wtog_q <= 1'b0; vptr_q <= '0; tptr_q <= '0;
      clr_q <= 1'b1; clr_cnt_q <= '0;
      s2v_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) mirror_q <= cfg_wdata_i;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + NaW'(1);
        if (&clr_cnt_q) clr_q <= 1'b0;
      end
      if (s2_ld_en) latch_q <= s2_ld;
      if (adv) begin
        ctrl_q <= ctrl_d; oam_q <= oam_d; vbl_q <= vbl_d; wtog_q <= wtog_d;
        vptr_q <= vptr_d; tptr_q <= tptr_d;
        s2v_q <= acc;
        if (s2v_q) ov_q <= 1'b1;
        else if (m_axis_tready) ov_q <= 1'b0;
      end
    end
  end

  // stage-2 payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rd_q  <= rd1;
      s2_nmi_q <= nmi_imm;
      s2_vbl_q <= vbl_d;
      s2_mem_q <= mem_d;
      s2_pal_q <= pal_d;
      s2_ltgt_q <= ltgt_d;
      s2_spr_q <= spr_d;
    end
  end

  logic [7:0] rd2;
  always_comb begin
    rd2 = s2_rd_q;
    if (s2_spr_q) rd2 = s_rdata;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2v_q) od_q <= {s2_vbl_q, s2_nmi_q, rd2};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'b0, od_q};

  a_nmi_vbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && od_q[8] |-> od_q[9]) else $error("nmi without vblank");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_stall |=> $stable(vptr_q) && $stable(oam_q)) else $error("state moved while stalled");
  a_pal_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2v_q && s2_pal_q |-> s2_mem_q) else $error("palette read flags");
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready) else $error("request accepted during clearing");
endmodule

// ----- sim/video_unit_register_port_tb.sv -----
// Testbench for video_unit_register_port: stream driver, monitor and an
// in-bench predictor of registers, memories and the dot/line counter.
// Depends on vurp_pkg and the RTL of the block.
module video_unit_register_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqNone = 2'd3;   // undefined request kind
  localparam logic [2:0] RegMask = 3'd1;
  localparam int unsigned WatchLimit = 10000;
  // window without idling on either side
  localparam int unsigned QuietFrom = 3000;
  localparam int unsigned QuietTo   = 3600;

  typedef struct packed {
    logic       vblank;
    logic       nmi;
    logic [7:0] rdata;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  always #6 clk_i = ~clk_i;

  video_unit_register_port DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // predictor state
  logic        mirror_v;
  logic [7:0]  ctrl;
  logic        vblank;
  logic [7:0]  oam_ptr;
  logic [7:0]  sprite_mem [vurp_pkg::SpriteMemDepth];
  logic [7:0]  buf_byte;
  logic [13:0] vaddr;
  logic [13:0] taddr;
  logic        toggle;
  logic [7:0]  name_mem [vurp_pkg::NameMemDepth];
  logic [7:0]  pal_mem [vurp_pkg::PaletteDepth];
  logic [7:0]  pat_mem [vurp_pkg::PatternMemDepth];
  logic        pat_written [vurp_pkg::PatternMemDepth];
  logic [8:0]  dot;
  logic [8:0]  line;

  logic [12:0] request_q[$];
  resp_t       expected_q[$];
  int unsigned errors = 0;
  int unsigned cycle = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_ticks = 0, n_reads = 0, n_writes = 0, n_nmi = 0, n_resp = 0;

  function automatic logic [10:0] name_index(input logic [13:0] a);
    logic bank;
    bank = mirror_v ? a[10] : a[11];
    return {bank, a[9:0]};
  endfunction

  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [7:0] vram_read(input logic [13:0] a);
    if (a < 14'h2000) return pat_mem[a[12:0]];
    if (a < 14'h3f00) return name_mem[name_index(a)];
    return pal_mem[pal_index(a)];
  endfunction

  function automatic void vram_write(input logic [13:0] a, input logic [7:0] d);
    if (a < 14'h2000) begin
      pat_mem[a[12:0]] = d;
      pat_written[a[12:0]] = 1'b1;
    end else if (a < 14'h3f00) begin
      name_mem[name_index(a)] = d;
    end else begin
      pal_mem[pal_index(a)] = d;
    end
  endfunction

  function automatic void bump_vaddr();
    vaddr = vaddr + (ctrl[2] ? 14'd32 : 14'd1);
  endfunction

  function automatic resp_t apply_request(input logic [1:0] kind, input logic [2:0] rg,
                                          input logic [7:0] d);
    resp_t r;
    logic [13:0] a;
    logic [7:0] v;
    r = '0;
    case (kind)
      vurp_pkg::ReqRead: begin
        if (rg == vurp_pkg::RegStatus) begin
          r.rdata = {vblank, 2'b00, buf_byte[4:0]};
          vblank = 1'b0;
          toggle = 1'b0;
        end else if (rg == vurp_pkg::RegOamDat) begin
          r.rdata = sprite_mem[oam_ptr];
        end else if (rg == vurp_pkg::RegData) begin
          a = vaddr;
          v = vram_read(a);
          bump_vaddr();
          if (a >= vurp_pkg::PaletteBase) begin
            buf_byte = vram_read(a - 14'h1000);
            r.rdata = v;
          end else begin
            r.rdata = buf_byte;
            buf_byte = v;
          end
        end
      end
      vurp_pkg::ReqWrite: begin
        case (rg)
          vurp_pkg::RegCtrl:   ctrl = d;
          vurp_pkg::RegOamAdr: oam_ptr = d;
          vurp_pkg::RegOamDat: begin
            sprite_mem[oam_ptr] = d;
            oam_ptr = oam_ptr + 8'd1;
          end
          vurp_pkg::RegScroll: toggle = ~toggle;
          vurp_pkg::RegAddr: begin
            if (!toggle) taddr = {d[5:0], 8'h00};
            else begin
              taddr = {taddr[13:8], d};
              vaddr = taddr;
            end
            toggle = ~toggle;
          end
          vurp_pkg::RegData: begin
            vram_write(vaddr, d);
            bump_vaddr();
          end
          default: ;
        endcase
      end
      vurp_pkg::ReqTick: begin
        dot = dot + 9'd1;
        if (line == vurp_pkg::VblankLine && dot == 9'd1) begin
          vblank = 1'b1;
          r.nmi = ctrl[7];
        end else if (line == vurp_pkg::PreLine && dot == 9'd1) begin
          vblank = 1'b0;
        end
        if (dot > vurp_pkg::LastDot) begin
          dot = '0;
          line = (line == vurp_pkg::PreLine) ? 9'd0 : line + 9'd1;
        end
      end
      default: ;
    endcase
    r.vblank = vblank;
    return r;
  endfunction

  // queue one request and its prediction; never reads unwritten pattern memory
  task automatic send(input logic [1:0] kind, input logic [2:0] rg, input logic [7:0] d);
    resp_t r;
    if (kind == vurp_pkg::ReqRead && rg == vurp_pkg::RegData && vaddr < 14'h2000 &&
        !pat_written[vaddr[12:0]])
      kind = vurp_pkg::ReqWrite;
    r = apply_request(kind, rg, d);
    case (kind)
      vurp_pkg::ReqRead:  n_reads++;
      vurp_pkg::ReqWrite: n_writes++;
      vurp_pkg::ReqTick:  n_ticks++;
      default:  ;
    endcase
    if (r.nmi) n_nmi++;
    request_q.push_back({d, rg, kind});
    expected_q.push_back(r);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_mirror(input logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mirror_v = v;
  endtask

  task automatic random_burst();
    int unsigned r, n;
    logic [7:0] hi;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 1)) send(vurp_pkg::ReqRead, vurp_pkg::RegStatus, 8'($urandom));
      hi = 8'($urandom);
      if ($urandom_range(0, 2) == 0) hi[5:0] = 6'h3f;
      send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, hi);
      send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) send($urandom_range(0, 1) ? vurp_pkg::ReqRead : vurp_pkg::ReqWrite,
                      vurp_pkg::RegData, 8'($urandom));
    end else if (r < 50) begin
      send(vurp_pkg::ReqWrite, vurp_pkg::RegOamAdr, 8'($urandom));
      n = $urandom_range(1, 4);
      repeat (n) send(vurp_pkg::ReqWrite, vurp_pkg::RegOamDat, 8'($urandom));
      send(vurp_pkg::ReqWrite, vurp_pkg::RegOamAdr, 8'($urandom));
      repeat (n) send(vurp_pkg::ReqRead, vurp_pkg::RegOamDat, 8'($urandom));
    end else if (r < 60) begin
      send(vurp_pkg::ReqWrite, vurp_pkg::RegCtrl, 8'($urandom));
    end else if (r < 80) begin
      n = $urandom_range(1, 20);
      repeat (n) send(vurp_pkg::ReqTick, 3'($urandom), 8'($urandom));
    end else begin
      send(2'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (request_q.size() != 0 &&
          ((cycle > QuietFrom && cycle < QuietTo) || $urandom_range(0, 99) >= 33)) begin
        s_axis_tdata <= {3'b000, request_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // response monitor, ready pattern and watchdog
  always @(posedge clk_i) begin
    resp_t got, want;
    cycle <= cycle + 1;
    if (rst_ni) begin
      m_axis_tready <= (cycle > QuietFrom && cycle < QuietTo) || $urandom_range(0, 99) >= 33;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else if (request_q.size() != 0 || expected_q.size() != 0)
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[9:0];
        n_resp <= n_resp + 1;
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected response %h", $realtime, got);
        end else begin
          want = expected_q.pop_front();
          if (got.rdata !== want.rdata || got.nmi !== want.nmi ||
              got.vblank !== want.vblank || m_axis_tdata[15:10] !== '0) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected rd=%h nmi=%b vb=%b got rd=%h nmi=%b vb=%b",
                     $realtime, want.rdata, want.nmi, want.vblank,
                     got.rdata, got.nmi, got.vblank);
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: timeout, %0d responses outstanding", $realtime, expected_q.size());
        $display("video_unit_register_port_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    mirror_v = 1'b0; ctrl = '0; vblank = 1'b0; oam_ptr = '0; buf_byte = '0;
    vaddr = '0; taddr = '0; toggle = 1'b0; dot = '0; line = vurp_pkg::PreLine;
    foreach (sprite_mem[i]) sprite_mem[i] = '0;
    foreach (name_mem[i]) name_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (pat_mem[i]) begin
      pat_mem[i] = '0;
      pat_written[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every register, palette alias, wraps
    send(vurp_pkg::ReqRead, vurp_pkg::RegStatus, 8'h00);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'hff);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'hff);     // pointer 0x3fff
    send(vurp_pkg::ReqWrite, vurp_pkg::RegData, 8'hff);     // wraps to 0x0000
    send(vurp_pkg::ReqWrite, vurp_pkg::RegData, 8'h01);     // pattern byte 0x0000
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h3f);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h10);     // mirrored palette entry
    send(vurp_pkg::ReqWrite, vurp_pkg::RegData, 8'h5a);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h3f);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h00);
    send(vurp_pkg::ReqRead, vurp_pkg::RegData, 8'hff);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegCtrl, 8'h84);     // step 32, NMI enable
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h00);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegAddr, 8'h00);
    send(vurp_pkg::ReqRead, vurp_pkg::RegData, 8'h00);
    send(vurp_pkg::ReqRead, vurp_pkg::RegData, 8'h00);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegOamAdr, 8'hff);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegOamDat, 8'ha5);   // pointer wraps to zero
    send(vurp_pkg::ReqRead, vurp_pkg::RegOamDat, 8'h00);
    send(vurp_pkg::ReqWrite, RegMask, 8'hff);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegScroll, 8'h00);
    send(vurp_pkg::ReqWrite, vurp_pkg::RegStatus, 8'hff);
    send(vurp_pkg::ReqRead, RegMask, 8'h00);
    send(ReqNone, 3'd7, 8'hff);
    send(vurp_pkg::ReqTick, 3'd0, 8'h00);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_mirror(p[0] ? 1'b0 : 1'b1);
      while (request_q.size() < 200) random_burst();
      drain();
    end

    $display("covered %0d reads, %0d writes, %0d ticks in both mirroring modes",
             n_reads, n_writes, n_ticks);
    $display("%0d responses checked, %0d NMI requests, errors: %0d", n_resp, n_nmi, errors);
    if (errors == 0) $display("video_unit_register_port_tb OK");
    else $display("video_unit_register_port_tb NOT OK");
    $finish;
  end

endmodule
